/* design/lgge_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Life grid engine package
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lgge_pkg;

    localparam int GRID_SIDE_DEF = 64;

    // input beat fields, lowest bit first
    localparam int OPCODE_W    = 2;
    localparam int COORD_W     = 6;
    localparam int OPCODE_LSB  = 0;
    localparam int ROW_LSB     = OPCODE_LSB + OPCODE_W;
    localparam int COLUMN_LSB  = ROW_LSB + COORD_W;
    localparam int VALUE_LSB   = COLUMN_LSB + COORD_W;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    // wide enough to compare a coordinate against a grid side up to 511
    localparam int COORD_CMP_W = 9;

    // B3/S23
    localparam int BIRTH_COUNT   = 3;
    localparam int SURVIVE_COUNT = 2;
    localparam int COUNT_W       = 4;

    typedef enum logic [OPCODE_W-1:0] {
        OPC_WRITE   = 2'd0,
        OPC_ADVANCE = 2'd1,
        OPC_READ    = 2'd2
    } t_opcode;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_WR_READ,
        ST_WR_MODIFY,
        ST_RD_READ,
        ST_RD_OUT,
        ST_ADV_RD_PREV,
        ST_ADV_RD_CUR,
        ST_ADV_RD_NEXT,
        ST_ADV_CAPTURE,
        ST_ADV_WRITE
    } t_state;

    typedef enum logic [1:0] {
        WR_ZERO,
        WR_CELL,
        WR_LIFE
    } t_wr_src;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_SCAN_PREV,
        ROW_SCAN,
        ROW_SCAN_NEXT
    } t_row_sel;

    typedef enum logic [1:0] {
        CAP_NONE,
        CAP_PREV,
        CAP_CUR,
        CAP_NEXT
    } t_win_cap;

    typedef struct packed {
        logic     item_load;
        logic     rd_en;
        logic     wr_en;
        t_wr_src  wr_src;
        t_row_sel row_sel;
        logic     other_buf;
        t_win_cap win_cap;
        logic     scan_clr;
        logic     scan_inc;
        logic     flip;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic                on_grid;
        logic                scan_last;
        logic                out_busy;
    } t_dp_status;

endpackage
`default_nettype wire

/* design/lgge_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Life grid engine datapath
// Row-wide double-buffered grid memory, three-row window, rule logic,
// item register and result register.
// ----------------------------------------------------------------------------
module lgge_datapath import lgge_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status,
    input  wire [IN_TDATA_W-1:0]   i_s_tdata,
    output logic                   o_m_tvalid,
    input  wire                    i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int RW    = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
    localparam int SLOTS = 2 ** RW;
    localparam int AW    = RW + 1;

    logic [GRID_SIDE-1:0] mem [2*SLOTS];

    logic [OPCODE_W-1:0]  r_opcode;
    logic [COORD_W-1:0]   r_row;
    logic [COORD_W-1:0]   r_col;
    logic                 r_value;
    logic                 r_cur;
    logic [RW-1:0]        r_scan;
    logic [GRID_SIDE-1:0] r_rd_data;
    logic [GRID_SIDE-1:0] r_win_prev;
    logic [GRID_SIDE-1:0] r_win_cur;
    logic [GRID_SIDE-1:0] r_win_next;
    logic                 r_out_valid;
    logic                 r_out_value;

    logic [RW-1:0]        w_row_item;
    logic [RW-1:0]        w_col_item;
    logic [RW-1:0]        w_row_prev;
    logic [RW-1:0]        w_row_next;
    logic [RW-1:0]        w_row;
    logic                 w_bank;
    logic [AW-1:0]        w_addr;
    logic                 w_on_grid;
    logic                 w_scan_last;
    logic                 w_out_busy;
    logic                 w_cell;
    logic [GRID_SIDE-1:0] w_cell_row;
    logic [GRID_SIDE-1:0] w_life_row;
    logic [GRID_SIDE-1:0] w_wdata;

    assign w_row_item  = RW'(r_row);
    assign w_col_item  = RW'(r_col);
    assign w_scan_last = (r_scan == RW'(GRID_SIDE - 1));
    assign w_row_prev  = (r_scan == '0) ? RW'(GRID_SIDE - 1) : r_scan - 1'b1;
    assign w_row_next  = w_scan_last ? '0 : r_scan + 1'b1;
    assign w_on_grid   = (COORD_CMP_W'(r_row) < COORD_CMP_W'(GRID_SIDE)) &&
                         (COORD_CMP_W'(r_col) < COORD_CMP_W'(GRID_SIDE));
    assign w_out_busy  = r_out_valid && !i_m_tready;

    always_comb begin
        case (i_cmd.row_sel)
            ROW_ITEM:      w_row = w_row_item;
            ROW_SCAN_PREV: w_row = w_row_prev;
            ROW_SCAN:      w_row = r_scan;
            ROW_SCAN_NEXT: w_row = w_row_next;
            default:       w_row = r_scan;
        endcase
    end

    assign w_bank = i_cmd.other_buf ? ~r_cur : r_cur;
    assign w_addr = {w_bank, w_row};

    // pick the addressed cell out of the fetched row and patch it for writes
    always_comb begin
        w_cell = 1'b0;
        for (int c = 0; c < GRID_SIDE; c++) begin
            if (w_col_item == RW'(c)) begin
                w_cell_row[c] = r_value;
                w_cell        = w_cell | r_rd_data[c];
            end else begin
                w_cell_row[c] = r_rd_data[c];
            end
        end
    end

    // next generation of the window's middle row, columns wrap around
    always_comb begin
        int                 cl;
        int                 cr;
        logic [COUNT_W-1:0] cnt;
        for (int c = 0; c < GRID_SIDE; c++) begin
            cl  = (c == 0) ? GRID_SIDE - 1 : c - 1;
            cr  = (c == GRID_SIDE - 1) ? 0 : c + 1;
            cnt = COUNT_W'(r_win_prev[cl]) + COUNT_W'(r_win_prev[c]) +
                  COUNT_W'(r_win_prev[cr]) + COUNT_W'(r_win_cur[cl]) +
                  COUNT_W'(r_win_cur[cr])  + COUNT_W'(r_win_next[cl]) +
                  COUNT_W'(r_win_next[c])  + COUNT_W'(r_win_next[cr]);
            w_life_row[c] = (cnt == COUNT_W'(BIRTH_COUNT)) ||
                            (r_win_cur[c] && (cnt == COUNT_W'(SURVIVE_COUNT)));
        end
    end

    always_comb begin
        case (i_cmd.wr_src)
            WR_ZERO: w_wdata = '0;
            WR_CELL: w_wdata = w_cell_row;
            WR_LIFE: w_wdata = w_life_row;
            default: w_wdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[w_addr] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.item_load) begin
            r_opcode <= i_s_tdata[OPCODE_LSB +: OPCODE_W];
            r_row    <= i_s_tdata[ROW_LSB +: COORD_W];
            r_col    <= i_s_tdata[COLUMN_LSB +: COORD_W];
            r_value  <= i_s_tdata[VALUE_LSB];
        end
        case (i_cmd.win_cap)
            CAP_PREV: r_win_prev <= r_rd_data;
            CAP_CUR:  r_win_cur  <= r_rd_data;
            CAP_NEXT: r_win_next <= r_rd_data;
            default:  ;
        endcase
        if (i_cmd.out_load) begin
            r_out_value <= w_on_grid & w_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur       <= 1'b0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.flip) begin
                r_cur <= ~r_cur;
            end
            if (i_cmd.scan_clr) begin
                r_scan <= '0;
            end else if (i_cmd.scan_inc) begin
                r_scan <= r_scan + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.opcode    = r_opcode;
    assign o_status.on_grid   = w_on_grid;
    assign o_status.scan_last = w_scan_last;
    assign o_status.out_busy  = w_out_busy;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W - 1){1'b0}}, r_out_value};

endmodule
`default_nettype wire

/* design/lgge_controller.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Life grid engine controller
// Sequences the clearing pass, cell writes, cell reads and generation steps.
// ----------------------------------------------------------------------------
module lgge_controller import lgge_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_s_tvalid,
    output logic       o_s_tready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_src  = WR_ZERO;
                o_cmd.row_sel = ROW_SCAN;
                if (i_status.scan_last) begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            ST_IDLE: begin
                o_s_tready      = 1'b1;
                o_cmd.item_load = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (t_opcode'(i_status.opcode))
                    OPC_WRITE:   n_state = i_status.on_grid ? ST_WR_READ : ST_IDLE;
                    OPC_ADVANCE: n_state = ST_ADV_RD_PREV;
                    OPC_READ:    n_state = ST_RD_READ;
                    default:     n_state = ST_IDLE;
                endcase
            end
            ST_WR_READ: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.row_sel = ROW_ITEM;
                n_state       = ST_WR_MODIFY;
            end
            ST_WR_MODIFY: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_src  = WR_CELL;
                o_cmd.row_sel = ROW_ITEM;
                n_state       = ST_IDLE;
            end
            ST_RD_READ: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.row_sel = ROW_ITEM;
                n_state       = ST_RD_OUT;
            end
            ST_RD_OUT: begin
                // hold until the result register is free
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_ADV_RD_PREV: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.row_sel = ROW_SCAN_PREV;
                n_state       = ST_ADV_RD_CUR;
            end
            ST_ADV_RD_CUR: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.row_sel = ROW_SCAN;
                o_cmd.win_cap = CAP_PREV;
                n_state       = ST_ADV_RD_NEXT;
            end
            ST_ADV_RD_NEXT: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.row_sel = ROW_SCAN_NEXT;
                o_cmd.win_cap = CAP_CUR;
                n_state       = ST_ADV_CAPTURE;
            end
            ST_ADV_CAPTURE: begin
                o_cmd.win_cap = CAP_NEXT;
                n_state       = ST_ADV_WRITE;
            end
            ST_ADV_WRITE: begin
                o_cmd.wr_en     = 1'b1;
                o_cmd.wr_src    = WR_LIFE;
                o_cmd.row_sel   = ROW_SCAN;
                o_cmd.other_buf = 1'b1;
                if (i_status.scan_last) begin
                    // last row done: swap buffers
                    o_cmd.scan_clr = 1'b1;
                    o_cmd.flip     = 1'b1;
                    n_state        = ST_IDLE;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                    n_state        = ST_ADV_RD_PREV;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* design/life_grid_generation_engine_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Life grid generation engine
// Toroidal B3/S23 grid with cell write, cell read and generation step.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one command beat per handshake: write a cell, advance
//   one generation, or read a cell. Only a read produces a master beat.
//   Off-grid writes are dropped; off-grid reads return 0.
//   Tready stays low while a command is carried out; a read's result
//   becomes valid in the same cycle that tready is high again.
//   An advance handles each grid row in turn on the single memory port:
//   three row reads into a window, a capture, and one row write of the new
//   generation into the other buffer; the buffers swap after the last row.
//   Reset: both directions go idle and the current buffer is cleared one
//   row a cycle, with tready low, before the first beat.
//   Master stall: the result is held in its register; write and advance
//   commands are still taken, and a following read waits for the register.
// ----------------------------------------------------------------------------
module life_grid_generation_engine_unit import lgge_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_s_tvalid,
    output logic                   o_s_tready,
    // [1:0] opcode, [7:2] row, [13:8] column, [14] cell_value, [15] zero
    input  wire [IN_TDATA_W-1:0]   i_s_tdata,
    output logic                   o_m_tvalid,
    input  wire                    i_m_tready,
    // [0] read_value, [7:1] zero
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    lgge_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    lgge_datapath #(
        .GRID_SIDE (GRID_SIDE)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
`default_nettype wire

/* design/lgge_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Life grid engine port checker
// Port-level properties of the engine, bound to the top level.
// ----------------------------------------------------------------------------
module lgge_checker import lgge_pkg::*; (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_s_tvalid,
    input wire                   o_s_tready,
    input wire                   o_m_tvalid,
    input wire                   i_m_tready,
    input wire [OUT_TDATA_W-1:0] o_m_tdata
);

    // stalled result beat stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result data changed while stalled");

    // clearing pass keeps the slave side closed after reset
    a_reset_closed: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready && !o_m_tvalid)
        else $error("engine open right after reset");

    // every command is decoded before the next is taken
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second command taken without decode cycle");

    // a new result only comes out of a busy read sequence
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(!o_s_tready))
        else $error("result appeared while engine was idle");

endmodule

bind life_grid_generation_engine_unit lgge_checker u_lgge_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Life grid generation engine testbench
// Drives write, advance, read and unused-opcode beats into the slave stream and
// keeps its own toroidal B3/S23 grid, built up from the accepted commands.
// Each read beat on the master stream is compared with the cell value that
// this grid holds when the read is accepted. The sender idles in random bursts.
// The receiver stalls on its own pattern and holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
    import lgge_pkg::*;

    localparam int          GRID        = GRID_SIDE_DEF;
    localparam logic [1:0]  OPC_UNUSED  = 2'd3;
    localparam int          ITEM_TARGET = 140;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          HOLD_CYCLES = 600;

    logic                   i_clk    = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tready = 1'b0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // current generation as seen from the command stream
    bit [GRID-1:0] life_cells [GRID];
    bit            expected_reads [$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int burst_left     = 0;
    int hold_start     = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    logic [7:0] rx_tick = '0;

    always #5 i_clk = ~i_clk;

    life_grid_generation_engine_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    function automatic void advance_life_grid();
        bit [GRID-1:0] next_cells [GRID];
        int count;
        int rr;
        int cc;
        for (int r = 0; r < GRID; r++) begin
            for (int c = 0; c < GRID; c++) begin
                count = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        if (dr != 0 || dc != 0) begin
                            rr = (r + dr + GRID) % GRID;
                            cc = (c + dc + GRID) % GRID;
                            count += life_cells[rr][cc];
                        end
                    end
                end
                if (life_cells[r][c])
                    next_cells[r][c] = (count == SURVIVE_COUNT) || (count == BIRTH_COUNT);
                else
                    next_cells[r][c] = (count == BIRTH_COUNT);
            end
        end
        life_cells = next_cells;
    endfunction

    function automatic void update_life_grid(logic [1:0] op, logic [5:0] row,
                                             logic [5:0] column, logic value);
        bit on_grid;
        on_grid = (row < GRID) && (column < GRID);
        case (op)
            OPC_WRITE: begin
                if (on_grid)
                    life_cells[row][column] = value;
            end
            OPC_ADVANCE: advance_life_grid();
            OPC_READ: expected_reads.push_back(on_grid ? life_cells[row][column] : 1'b0);
            default: ;
        endcase
    endfunction

    task automatic send_cmd(logic [1:0] op, logic [5:0] row, logic [5:0] column,
                            logic value);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(8, 60)) @(posedge i_clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, value, column, row, op};
        do @(posedge i_clk); while (!s_tready);
        update_life_grid(op, row, column, value);
        if (op != OPC_UNUSED)
            items_sent++;
    endtask

    // corners of the torus touch each other: four live corners form a block
    task automatic test_corner_wrap();
        send_cmd(OPC_WRITE, 6'd0, 6'd0, 1'b1);
        send_cmd(OPC_WRITE, 6'd63, 6'd63, 1'b1);
        send_cmd(OPC_WRITE, 6'd0, 6'd63, 1'b1);
        send_cmd(OPC_WRITE, 6'd63, 6'd0, 1'b1);
        send_cmd(OPC_READ, 6'd0, 6'd0, 1'b0);
        send_cmd(OPC_READ, 6'd63, 6'd63, 1'b1);
        send_cmd(OPC_READ, 6'd1, 6'd1, 1'b1);
        send_cmd(OPC_UNUSED, 6'd63, 6'd63, 1'b1);
        send_cmd(OPC_ADVANCE, 6'd63, 6'd63, 1'b1);
        send_cmd(OPC_READ, 6'd0, 6'd63, 1'b0);
        send_cmd(OPC_READ, 6'd63, 6'd0, 1'b0);
        send_cmd(OPC_READ, 6'd62, 6'd62, 1'b0);
        send_cmd(OPC_READ, 6'd1, 6'd0, 1'b0);
    endtask

    // horizontal blinker turns vertical after one generation
    task automatic test_blinker();
        send_cmd(OPC_WRITE, 6'd10, 6'd20, 1'b1);
        send_cmd(OPC_WRITE, 6'd10, 6'd21, 1'b1);
        send_cmd(OPC_WRITE, 6'd10, 6'd22, 1'b1);
        send_cmd(OPC_ADVANCE, 6'd0, 6'd0, 1'b0);
        send_cmd(OPC_READ, 6'd9, 6'd21, 1'b0);
        send_cmd(OPC_READ, 6'd11, 6'd21, 1'b0);
        send_cmd(OPC_READ, 6'd10, 6'd20, 1'b0);
        send_cmd(OPC_WRITE, 6'd10, 6'd21, 1'b0);
        send_cmd(OPC_READ, 6'd10, 6'd21, 1'b1);
    endtask

    // hold the master side off while commands keep coming
    task automatic test_stalled_output();
        hold_start = hold_start + 1;
        send_cmd(OPC_WRITE, 6'd30, 6'd30, 1'b1);
        send_cmd(OPC_READ, 6'd30, 6'd30, 1'b0);
        send_cmd(OPC_WRITE, 6'd30, 6'd31, 1'b1);
        send_cmd(OPC_WRITE, 6'd30, 6'd32, 1'b1);
        send_cmd(OPC_READ, 6'd30, 6'd31, 1'b0);
        send_cmd(OPC_READ, 6'd29, 6'd31, 1'b0);
        send_cmd(OPC_ADVANCE, 6'd0, 6'd0, 1'b1);
        send_cmd(OPC_READ, 6'd29, 6'd31, 1'b0);
        send_cmd(OPC_READ, 6'd31, 6'd31, 1'b0);
        send_cmd(OPC_READ, 6'd30, 6'd30, 1'b0);
    endtask

    // seed a small window, step it up to two generations, read the window back
    task automatic test_random_patterns();
        logic [5:0] base_row;
        logic [5:0] base_col;
        logic [1:0] op;
        while (items_sent < ITEM_TARGET) begin
            base_row = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(61, 63))
                                                   : 6'($urandom_range(0, 63));
            base_col = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(61, 63))
                                                   : 6'($urandom_range(0, 63));
            repeat ($urandom_range(4, 10))
                send_cmd(OPC_WRITE, 6'(base_row + $urandom_range(0, 4)),
                         6'(base_col + $urandom_range(0, 4)),
                         1'($urandom_range(0, 2) != 0));
            repeat ($urandom_range(0, 2))
                send_cmd(OPC_ADVANCE, 6'($urandom), 6'($urandom), 1'($urandom));
            repeat ($urandom_range(3, 8))
                send_cmd(OPC_READ, 6'(base_row + $urandom_range(0, 6) - 1),
                         6'(base_col + $urandom_range(0, 6) - 1), 1'($urandom));
            repeat ($urandom_range(0, 2)) begin
                op = 2'($urandom_range(0, 3));
                // keep full-grid steps rare among the noise beats
                if (op == OPC_ADVANCE && $urandom_range(0, 1) == 0)
                    op = OPC_READ;
                send_cmd(op, 6'($urandom), 6'($urandom), 1'($urandom));
            end
        end
    endtask

    // receiver: rotate through stall patterns, honor a requested hold-off
    always @(posedge i_clk) begin
        if (hold_seen != hold_start) begin
            hold_seen <= hold_start;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            rx_tick <= rx_tick + 8'd1;
            case (rx_tick[7:6])
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= (rx_tick[1:0] != 2'd3);
                2'd2: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= (rx_tick[2:0] == 3'd0);
            endcase
        end
    end

    // compare each read beat with the oldest pending cell value
    always @(posedge i_clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_reads.size() == 0) begin
                $display("%0t unexpected read beat: expected none, got %h", $time, m_tdata);
                mismatch_count++;
            end else if (m_tdata !== {{(OUT_TDATA_W-1){1'b0}}, expected_reads[0]}) begin
                $display("%0t read mismatch: expected %h, got %h", $time,
                         {{(OUT_TDATA_W-1){1'b0}}, expected_reads[0]}, m_tdata);
                mismatch_count++;
                void'(expected_reads.pop_front());
            end else begin
                void'(expected_reads.pop_front());
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        test_corner_wrap();
        test_blinker();
        test_stalled_output();
        test_random_patterns();
        burst_left = 0;
        s_tvalid <= 1'b0;
        while (expected_reads.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_reads.size() != 0) begin
            $display("%0t pending reads left: expected 0, got %0d", $time,
                     expected_reads.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("%0t timeout: expected drain, got %0d pending reads", $time,
                 expected_reads.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
